// ----- hw/rtl/iff_pkg.sv -----
// Shared types, constants and helpers for the integer field formatter.
package iff_pkg;

    localparam int MAX_WIDTH_DEF = 63;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NUM_DIGITS    = 10;
    localparam int FW_BITS       = 6;

    localparam logic [1:0] KIND_SDEC     = 2'd0;
    localparam logic [1:0] KIND_UDEC     = 2'd1;
    localparam logic [1:0] KIND_HEX_LOW  = 2'd2;
    localparam logic [1:0] KIND_HEX_UP   = 2'd3;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_LOW_A = 7'h61;
    localparam logic [6:0] CH_UP_A  = 7'h41;

    // 2^35 / 10 rounded up; exact quotient for every 32-bit operand
    localparam logic [63:0] RECIP_10 = 64'h0000_0000_CCCC_CCCD;

    typedef struct packed {
        logic [31:0]        mag;
        logic               hex;
        logic               upper;
        logic               neg;
        logic [FW_BITS-1:0] width;
        logic               left_align;
        logic               zero_fill;
    } iff_item_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {3'b000, d};
        end else if (upper) begin
            r = CH_UP_A + {3'b000, d - 4'd10};
        end else begin
            r = CH_LOW_A + {3'b000, d - 4'd10};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/integer_field_formatter.sv -----
// Sequence: the back stage loads an item, extracts its D digits (1..10) one digit step per
//   cycle, registers the field layout, then issues the C characters of the field (1..63)
//   one character beat per cycle while its output register is free; m_valid is registered.
//   It takes no new item until the last character beat of the current one is issued.
// The front stage and a two-entry queue take new beats while the back stage is busy.
// Reset: aresetn is synchronous, active low; clears valids, queue pointers and the sequencer.
module integer_field_formatter #(
    parameter int MAX_WIDTH = iff_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [31:0]                 s_value,
    input  logic [1:0]                  s_kind,
    input  logic [iff_pkg::FW_BITS-1:0] s_field_width,
    input  logic                        s_left_align,
    input  logic                        s_zero_fill,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [6:0]                  m_char_code,
    output logic                        m_last
);

    logic               push_valid, push_ready;
    iff_pkg::iff_item_t push_item;
    logic               pop_valid, pop_ready;
    iff_pkg::iff_item_t pop_item;

    iff_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_kind        (s_kind),
        .s_field_width (s_field_width),
        .s_left_align  (s_left_align),
        .s_zero_fill   (s_zero_fill),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    iff_queue #(
        .DEPTH(iff_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    iff_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

endmodule

// ----- hw/rtl/iff_front.sv -----
// Front stage: accepts a beat, resolves sign, magnitude and width, hands it to the queue.
module iff_front #(
    parameter int MAX_WIDTH = iff_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_value,
    input  logic [1:0]                    s_kind,
    input  logic [iff_pkg::FW_BITS-1:0]   s_field_width,
    input  logic                          s_left_align,
    input  logic                          s_zero_fill,
    output logic                          push_valid,
    input  logic                          push_ready,
    output iff_pkg::iff_item_t            push_item
);

    localparam int FW_W = iff_pkg::FW_BITS;

    logic               vld_reg, vld_next;
    iff_pkg::iff_item_t item_reg, item_next;
    logic               take;

    assign s_ready    = !vld_reg || push_ready;
    assign take       = s_valid && s_ready;
    assign push_valid = vld_reg;
    assign push_item  = item_reg;

    always_comb begin
        item_next            = item_reg;
        item_next.hex        = s_kind[1];
        item_next.upper      = (s_kind == iff_pkg::KIND_HEX_UP);
        item_next.neg        = (s_kind == iff_pkg::KIND_SDEC) && s_value[31];
        item_next.mag        = item_next.neg ? (32'd0 - s_value) : s_value;
        item_next.width      = (s_field_width > FW_W'(MAX_WIDTH)) ?
                               FW_W'(MAX_WIDTH) : s_field_width;
        item_next.left_align = s_left_align;
        item_next.zero_fill  = s_zero_fill;

        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (push_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hw/rtl/iff_queue.sv -----
// Small register queue between the front and back stages.
module iff_queue #(
    parameter int DEPTH = iff_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  iff_pkg::iff_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output iff_pkg::iff_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iff_pkg::iff_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/iff_back.sv -----
// Back stage: digit extraction, field layout and one character beat per cycle while the output is free.
module iff_back #(
    parameter int MAX_WIDTH = iff_pkg::MAX_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  iff_pkg::iff_item_t pop_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [6:0]         m_char_code,
    output logic               m_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int DI = $clog2(iff_pkg::NUM_DIGITS);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_DIGIT = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  mag_reg, mag_next;
    logic         hex_reg, upper_reg, neg_reg, right_reg, zero_reg;
    logic [WW-1:0] width_reg;
    logic [DI:0]  nd_reg, nd_next;
    logic [3:0]   digit_reg [iff_pkg::NUM_DIGITS];

    logic [WW-1:0] b1_reg, b2_reg, b3_reg, b4_reg, last_pos_reg;
    logic [WW-1:0] pos_reg, pos_next;
    logic [6:0]    pad_char_reg;

    logic         m_valid_reg, m_valid_next;
    logic [6:0]   m_char_reg;
    logic         m_last_reg;

    // digit step
    logic [63:0]  prod;
    logic [31:0]  quot;
    logic [3:0]   q10_lo;
    logic [3:0]   digit;

    // layout
    logic          lead;
    logic          tsign;
    logic [WW-1:0] len, weff, pad, b1, b2, b3, b4, last_pos;

    // emit
    logic          out_free;
    logic          emit;
    logic [WW-1:0] di_full;
    logic [6:0]    ch;

    assign pop_ready = (state_reg == ST_LOAD);

    assign prod   = {32'd0, mag_reg} * iff_pkg::RECIP_10;
    assign quot   = {3'd0, prod[63:35]};
    assign q10_lo = 4'({quot[0], 3'b000} + {quot[2:0], 1'b0});
    assign digit  = hex_reg ? mag_reg[3:0] : (mag_reg[3:0] - q10_lo);
    assign mag_next = hex_reg ? {4'd0, mag_reg[31:4]} : quot;
    assign nd_next  = nd_reg + 1'b1;

    always_comb begin
        lead     = neg_reg && (width_reg != '0) && zero_reg;
        tsign    = neg_reg && !lead;
        len      = WW'(nd_reg) + WW'(tsign);
        weff     = width_reg - WW'(lead);
        pad      = (weff > len) ? (weff - len) : '0;
        b1       = WW'(lead);
        b2       = b1 + (right_reg ? '0 : pad);
        b3       = b2 + WW'(tsign);
        b4       = b3 + WW'(nd_reg);
        last_pos = b4 + (right_reg ? pad : '0) - 1'b1;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg == ST_EMIT) && out_free;
    assign di_full  = b4_reg - 1'b1 - pos_reg;

    always_comb begin
        if (pos_reg < b1_reg) begin
            ch = iff_pkg::CH_MINUS;
        end else if (pos_reg < b2_reg) begin
            ch = pad_char_reg;
        end else if (pos_reg < b3_reg) begin
            ch = iff_pkg::CH_MINUS;
        end else if (pos_reg < b4_reg) begin
            ch = iff_pkg::digit_char(digit_reg[di_full[DI-1:0]], upper_reg);
        end else begin
            ch = pad_char_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_LOAD: begin
                if (pop_valid) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (mag_next == 32'd0) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    pos_next     = pos_reg + 1'b1;
                    if (pos_reg == last_pos_reg) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg <= pos_next;

        if (state_reg == ST_LOAD && pop_valid) begin
            mag_reg   <= pop_item.mag;
            hex_reg   <= pop_item.hex;
            upper_reg <= pop_item.upper;
            neg_reg   <= pop_item.neg;
            right_reg <= pop_item.left_align;
            zero_reg  <= pop_item.zero_fill;
            width_reg <= WW'(pop_item.width);
            nd_reg    <= '0;
        end

        if (state_reg == ST_DIGIT) begin
            digit_reg[nd_reg[DI-1:0]] <= digit;
            mag_reg <= mag_next;
            nd_reg  <= nd_next;
        end

        if (state_reg == ST_SETUP) begin
            b1_reg       <= b1;
            b2_reg       <= b2;
            b3_reg       <= b3;
            b4_reg       <= b4;
            last_pos_reg <= last_pos;
            pad_char_reg <= zero_reg ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
        end

        if (emit) begin
            m_char_reg <= ch;
            m_last_reg <= (pos_reg == last_pos_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

endmodule
